[rtl/core/hsl_pkg.sv]
package hsl_pkg;

   // fixed-point format of saturation and lightness
   localparam int FRAC_BITS = 12;
   localparam int FRAC_W    = 13;
   localparam int UNIT      = 1 << FRAC_BITS;
   localparam int HALF_UNIT = UNIT / 2;

   // hue in whole degrees
   localparam int HUE_W     = 9;
   localparam int HUE_W1    = HUE_W + 1;
   localparam int HUE_TURN  = 360;
   localparam int HUE_THIRD = 120;
   localparam int HUE_RISE  = 60;
   localparam int HUE_HOLD  = 180;
   localparam int HUE_FALL  = 240;

   // channel weight 0..60 along the hue ramp
   localparam int WGT_W     = 6;

   // levels scaled by UNIT squared, and the ramp numerator
   localparam int PROD_W    = 2 * FRAC_W;
   localparam int LVL_W     = 2 * FRAC_BITS + 1;
   localparam int NUM_W     = LVL_W + WGT_W;
   // numerator times 17, then divided by 4 * UNIT^2 (255 / 60 = 17 / 4)
   localparam int SCL_W     = NUM_W + 5;
   localparam int SCL_SHIFT = 2 * FRAC_BITS + 2;
   localparam int QUO_W     = SCL_W - SCL_SHIFT;

   localparam int CH_W      = 8;
   localparam int CH_MAX    = 255;

   // stream packing
   localparam int REQ_BITS  = HUE_W + 2 * FRAC_W;
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W     = 3 * CH_W;

   localparam int CH_RED    = 0;
   localparam int CH_GREEN  = 1;
   localparam int CH_BLUE   = 2;

   // register stages in the pipe
   localparam int NSTAGE    = 5;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } hsl_stage_en_type;

   typedef logic [WGT_W-1:0] hsl_wgt_type;
   typedef hsl_wgt_type [2:0] hsl_wgt_set_type;
   typedef logic [LVL_W-1:0] hsl_level_type;

endpackage

[rtl/core/hsl_front.sv]
module hsl_front (
   input  logic                        clock,
   input  hsl_pkg::hsl_stage_en_type   stage_en,
   input  logic [hsl_pkg::HUE_W-1:0]   hue_deg,
   input  logic [hsl_pkg::FRAC_W-1:0]  sat_frac,
   input  logic [hsl_pkg::FRAC_W-1:0]  light_frac,
   output hsl_pkg::hsl_wgt_set_type    wgt,
   output hsl_pkg::hsl_level_type      sat_lit,
   output logic [hsl_pkg::FRAC_W-1:0]  sat,
   output logic [hsl_pkg::FRAC_W-1:0]  lit
);
   import hsl_pkg::*;

   function automatic hsl_wgt_type hue_weight(input logic [HUE_W-1:0] h);
      hsl_wgt_type w;
      if (h < HUE_W'(HUE_RISE)) begin
         w = WGT_W'(h);
      end else if (h < HUE_W'(HUE_HOLD)) begin
         w = WGT_W'(HUE_RISE);
      end else if (h < HUE_W'(HUE_FALL)) begin
         w = WGT_W'(HUE_W'(HUE_FALL) - h);
      end else begin
         w = '0;
      end
      return w;
   endfunction

   logic [HUE_W-1:0]  hue_wrap;
   logic [HUE_W1-1:0] red_sum;
   logic [HUE_W1-1:0] blue_sum;
   logic [HUE_W-1:0]  hue_red;
   logic [HUE_W-1:0]  hue_blue;
   logic [FRAC_W-1:0] sat_clip;
   logic [FRAC_W-1:0] lit_clip;
   logic [PROD_W-1:0] prod;

   hsl_wgt_set_type   wgt1_ff, wgt1_in;
   logic [FRAC_W-1:0] sat1_ff, lit1_ff;
   hsl_wgt_set_type   wgt2_ff;
   logic [FRAC_W-1:0] sat2_ff, lit2_ff;
   hsl_level_type     sat_lit_ff, sat_lit_in;

   always_comb begin
      hue_wrap = (hue_deg >= HUE_W'(HUE_TURN)) ? hue_deg - HUE_W'(HUE_TURN) : hue_deg;
      red_sum  = {1'b0, hue_wrap} + HUE_W1'(HUE_THIRD);
      blue_sum = {1'b0, hue_wrap} + HUE_W1'(2 * HUE_THIRD);
      hue_red  = (red_sum >= HUE_W1'(HUE_TURN)) ? HUE_W'(red_sum - HUE_W1'(HUE_TURN))
                                                : HUE_W'(red_sum);
      hue_blue = (blue_sum >= HUE_W1'(HUE_TURN)) ? HUE_W'(blue_sum - HUE_W1'(HUE_TURN))
                                                 : HUE_W'(blue_sum);
      wgt1_in[CH_RED]   = hue_weight(hue_red);
      wgt1_in[CH_GREEN] = hue_weight(hue_wrap);
      wgt1_in[CH_BLUE]  = hue_weight(hue_blue);
      sat_clip = (sat_frac > FRAC_W'(UNIT)) ? FRAC_W'(UNIT) : sat_frac;
      lit_clip = (light_frac > FRAC_W'(UNIT)) ? FRAC_W'(UNIT) : light_frac;
      prod       = PROD_W'(sat1_ff) * PROD_W'(lit1_ff);
      sat_lit_in = prod[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         wgt1_ff <= wgt1_in;
         sat1_ff <= sat_clip;
         lit1_ff <= lit_clip;
      end
      if (stage_en.s2) begin
         wgt2_ff    <= wgt1_ff;
         sat2_ff    <= sat1_ff;
         lit2_ff    <= lit1_ff;
         sat_lit_ff <= sat_lit_in;
      end
   end

   assign wgt     = wgt2_ff;
   assign sat_lit = sat_lit_ff;
   assign sat     = sat2_ff;
   assign lit     = lit2_ff;

endmodule

[rtl/core/hsl_levels.sv]
module hsl_levels (
   input  logic                        clock,
   input  hsl_pkg::hsl_stage_en_type   stage_en,
   input  hsl_pkg::hsl_wgt_set_type    wgt_in,
   input  hsl_pkg::hsl_level_type      sat_lit,
   input  logic [hsl_pkg::FRAC_W-1:0]  sat,
   input  logic [hsl_pkg::FRAC_W-1:0]  lit,
   output hsl_pkg::hsl_wgt_set_type    wgt_out,
   output hsl_pkg::hsl_level_type      lo_lvl,
   output hsl_pkg::hsl_level_type      span_lvl
);
   import hsl_pkg::*;

   logic [FRAC_W:0] lit_plus_sat;
   logic [LVL_W:0]  lit_u;
   logic [LVL_W:0]  sum_u;
   logic [LVL_W:0]  prod_ext;
   logic [LVL_W:0]  hi_wide;
   logic [LVL_W:0]  two_lu;
   logic [LVL_W:0]  lo_wide;
   logic [LVL_W:0]  span_wide;

   hsl_wgt_set_type wgt_ff;
   hsl_level_type   lo_ff, lo_in;
   hsl_level_type   span_ff, span_in;

   always_comb begin
      lit_plus_sat = {1'b0, lit} + {1'b0, sat};
      lit_u        = (LVL_W + 1)'(lit) << FRAC_BITS;
      sum_u        = (LVL_W + 1)'(lit_plus_sat) << FRAC_BITS;
      prod_ext     = {1'b0, sat_lit};
      // upper level: L*(1+S) below half lightness, else L + S - S*L
      hi_wide   = (lit < FRAC_W'(HALF_UNIT)) ? lit_u + prod_ext : sum_u - prod_ext;
      two_lu    = lit_u << 1;
      lo_wide   = two_lu - {1'b0, hi_wide[LVL_W-1:0]};
      span_wide = {hi_wide[LVL_W-1:0], 1'b0} - two_lu;
      lo_in     = lo_wide[LVL_W-1:0];
      span_in   = span_wide[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         wgt_ff  <= wgt_in;
         lo_ff   <= lo_in;
         span_ff <= span_in;
      end
   end

   assign wgt_out  = wgt_ff;
   assign lo_lvl   = lo_ff;
   assign span_lvl = span_ff;

endmodule

[rtl/core/hsl_chan.sv]
module hsl_chan (
   input  logic                       clock,
   input  hsl_pkg::hsl_stage_en_type  stage_en,
   input  hsl_pkg::hsl_level_type     lo_lvl,
   input  hsl_pkg::hsl_level_type     span_lvl,
   input  hsl_pkg::hsl_wgt_type       wgt,
   output logic [hsl_pkg::CH_W-1:0]   level
);
   import hsl_pkg::*;

   logic [NUM_W-1:0] lo_x60;
   logic [NUM_W-1:0] ramp;
   logic [SCL_W-1:0] scaled;
   logic [QUO_W-1:0] quot;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [CH_W-1:0]  level_ff, level_in;

   always_comb begin
      // 60 * lo as 64 * lo - 4 * lo
      lo_x60 = (NUM_W'(lo_lvl) << 6) - (NUM_W'(lo_lvl) << 2);
      ramp   = NUM_W'(span_lvl) * NUM_W'(wgt);
      num_in = lo_x60 + ramp;
      // times 255 / 60 and unscaled: 17 * num / (4 * UNIT^2)
      scaled   = (SCL_W'(num_ff) << 4) + SCL_W'(num_ff);
      quot     = scaled[SCL_W-1:SCL_SHIFT];
      level_in = (quot > QUO_W'(CH_MAX)) ? CH_W'(CH_MAX) : quot[CH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         num_ff <= num_in;
      end
      if (stage_en.s5) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

[rtl/core/hsl_to_rgb_converter.sv]
// hsl to rgb pixel converter, five register stages
// throughput: one beat per cycle while rsp is not stalled; the multiplier stages and the output register set the depth
// stalls hold each stage in place, and bubbles are squeezed out while rsp is stalled
// reset: synchronous, clears the stage valid bits only; data registers are not reset
module hsl_to_rgb_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [hsl_pkg::REQ_W-1:0]  req_tdata,   // hue_deg, sat_frac, light_frac, zero pad
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [hsl_pkg::RSP_W-1:0]  rsp_tdata    // red_out, green_out, blue_out
);
   import hsl_pkg::*;

   // unpacked input fields
   logic [HUE_W-1:0]  hue_deg;
   logic [FRAC_W-1:0] sat_frac;
   logic [FRAC_W-1:0] light_frac;

   // stage valid bits and per-stage ready, index 1 is the input stage
   logic [NSTAGE:1] valid_ff, valid_in;
   logic [NSTAGE:1] stage_rdy;
   hsl_stage_en_type stage_en;

   // datapath between the units
   hsl_wgt_set_type  wgt_s2, wgt_s3;
   hsl_level_type    sat_lit_s2;
   logic [FRAC_W-1:0] sat_s2, lit_s2;
   hsl_level_type    lo_s3, span_s3;
   logic [CH_W-1:0]  red_out, green_out, blue_out;

   assign hue_deg    = req_tdata[HUE_W-1:0];
   assign sat_frac   = req_tdata[HUE_W+FRAC_W-1:HUE_W];
   assign light_frac = req_tdata[HUE_W+2*FRAC_W-1:HUE_W+FRAC_W];

   // a stage may load when it is empty or the stage after it moves on
   always_comb begin
      stage_rdy[NSTAGE] = !valid_ff[NSTAGE] || rsp_tready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in[1] = stage_rdy[1] ? req_tvalid : valid_ff[1];
      for (int k = 2; k <= NSTAGE; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
      stage_en.s1 = stage_rdy[1];
      stage_en.s2 = stage_rdy[2];
      stage_en.s3 = stage_rdy[3];
      stage_en.s4 = stage_rdy[4];
      stage_en.s5 = stage_rdy[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stages 1 and 2: hue wrap and ramp weights, clamping, S*L product
   hsl_front u_front (
      .clock      (clock),
      .stage_en   (stage_en),
      .hue_deg    (hue_deg),
      .sat_frac   (sat_frac),
      .light_frac (light_frac),
      .wgt        (wgt_s2),
      .sat_lit    (sat_lit_s2),
      .sat        (sat_s2),
      .lit        (lit_s2)
   );

   // stage 3: upper and lower levels, as lower level and span
   hsl_levels u_levels (
      .clock    (clock),
      .stage_en (stage_en),
      .wgt_in   (wgt_s2),
      .sat_lit  (sat_lit_s2),
      .sat      (sat_s2),
      .lit      (lit_s2),
      .wgt_out  (wgt_s3),
      .lo_lvl   (lo_s3),
      .span_lvl (span_s3)
   );

   // stages 4 and 5: per-channel ramp and scaling to 8 bits
   hsl_chan u_chan_red (
      .clock    (clock),
      .stage_en (stage_en),
      .lo_lvl   (lo_s3),
      .span_lvl (span_s3),
      .wgt      (wgt_s3[CH_RED]),
      .level    (red_out)
   );

   hsl_chan u_chan_green (
      .clock    (clock),
      .stage_en (stage_en),
      .lo_lvl   (lo_s3),
      .span_lvl (span_s3),
      .wgt      (wgt_s3[CH_GREEN]),
      .level    (green_out)
   );

   hsl_chan u_chan_blue (
      .clock    (clock),
      .stage_en (stage_en),
      .lo_lvl   (lo_s3),
      .span_lvl (span_s3),
      .wgt      (wgt_s3[CH_BLUE]),
      .level    (blue_out)
   );

   assign req_tready = stage_rdy[1];
   assign rsp_tvalid = valid_ff[NSTAGE];
   assign rsp_tdata  = {blue_out, green_out, red_out};

   // a full pipe with a stalled output must refuse new beats
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '1 && !rsp_tready) |-> !req_tready)
      else $error("input accepted while pipe full and output stalled");

   // a beat in stage 4 reaches the output when the output is free
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTAGE-1] && (!valid_ff[NSTAGE] || rsp_tready)) |=> rsp_tvalid)
      else $error("beat lost between ramp and output stage");

   // an accepted beat always lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[1])
      else $error("accepted beat did not enter the pipe");

endmodule

[test/hsl_to_rgb_converter_tb.sv]
module hsl_to_rgb_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsl_pkg::*;

   // req beat layout, lowest bits first: hue_deg, sat_frac, light_frac, zero pad
   localparam int PAD_W = REQ_W - REQ_BITS;

   localparam int RANDOM_PIXELS   = 1600;
   localparam int PHASE_PIXELS    = RANDOM_PIXELS / 3;
   // long receiver hold-off starts once this many pixels went in (no-idle phase)
   localparam int BACKPRESSURE_AT = 1250;
   localparam int HOLD_CYCLES     = 300;
   // quiet cycles with no beat on either side before the run is declared hung
   localparam int STALL_LIMIT     = 4000;
   // pipeline is five stages deep; the spare drain cycles catch stray rsp beats
   localparam int DRAIN_CYCLES    = 20;

   typedef struct packed {
      logic [PAD_W-1:0]  pad;
      logic [FRAC_W-1:0] light;
      logic [FRAC_W-1:0] sat;
      logic [HUE_W-1:0]  hue;
   } hsl_pixel_type;

   // rsp beat layout, lowest bits first: red_out, green_out, blue_out
   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } rgb_pixel_type;

   // expected colors in arrival order plus the conversion that produces them
   class rgb_scoreboard;
      rgb_pixel_type expected_rgb[$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      // one channel: piecewise-linear level over hue, scaled by 255, truncated and clamped to 255
      static function logic [CH_W-1:0] channel_level(longint unsigned lo2,
                                                     longint unsigned hi2,
                                                     int unsigned h);
         longint unsigned unit_sq;
         longint unsigned span;
         longint unsigned num;
         longint unsigned v;
         unit_sq = longint'(UNIT) * longint'(UNIT);
         span    = hi2 - lo2;
         if (h < HUE_RISE) begin
            num = lo2 * HUE_RISE + span * h;
         end else if (h < HUE_HOLD) begin
            num = hi2 * HUE_RISE;
         end else if (h < HUE_FALL) begin
            num = lo2 * HUE_RISE + span * (HUE_FALL - h);
         end else begin
            num = lo2 * HUE_RISE;
         end
         v = (num * CH_MAX) / (HUE_RISE * unit_sq);
         if (v > CH_MAX) begin
            v = CH_MAX;
         end
         return v[CH_W-1:0];
      endfunction

      static function rgb_pixel_type convert_hsl(hsl_pixel_type px);
         int unsigned     hue;
         longint unsigned unit;
         longint unsigned sat;
         longint unsigned lit;
         longint unsigned hi2;
         longint unsigned lo2;
         rgb_pixel_type   rgb;
         unit = UNIT;
         hue  = px.hue % HUE_TURN;
         sat  = px.sat;
         lit  = px.light;
         if (sat > unit) begin
            sat = unit;
         end
         if (lit > unit) begin
            lit = unit;
         end
         // both levels carry a scale of UNIT squared
         if (2 * lit < unit) begin
            hi2 = lit * (unit + sat);
         end else begin
            hi2 = (lit + sat) * unit - sat * lit;
         end
         lo2       = 2 * lit * unit - hi2;
         rgb.red   = channel_level(lo2, hi2, (hue + HUE_THIRD) % HUE_TURN);
         rgb.green = channel_level(lo2, hi2, hue);
         rgb.blue  = channel_level(lo2, hi2, (hue + 2 * HUE_THIRD) % HUE_TURN);
         return rgb;
      endfunction

      function void note_pixel(hsl_pixel_type px);
         expected_rgb.push_back(convert_hsl(px));
      endfunction

      function void compare_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
         if (want !== got) begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_pixel(rgb_pixel_type got);
         rgb_pixel_type want;
         if (expected_rgb.size() == 0) begin
            mismatches++;
            $error("rsp beat with nothing pending: %h", got);
            return;
         end
         want = expected_rgb.pop_front();
         compare_channel("red_out", want.red, got.red);
         compare_channel("green_out", want.green, got.green);
         compare_channel("blue_out", want.blue, got.blue);
      endfunction

      function int pending();
         return expected_rgb.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;    // hue_deg, sat_frac, light_frac, zero pad
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;    // red_out, green_out, blue_out

   rgb_scoreboard sb = new();

   // idle percentages per side, changed by the stimulus between phases
   int send_idle_pct = 31;
   int recv_idle_pct = 75;
   int pixels_sent   = 0;

   always #6 clock = ~clock;

   hsl_to_rgb_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // offer one pixel, with random idle cycles ahead of it, and wait for the handshake
   task automatic send_hsl(input int unsigned hue, input int unsigned sat,
                           input int unsigned light);
      hsl_pixel_type px;
      px.pad   = '0;
      px.hue   = hue[HUE_W-1:0];
      px.sat   = sat[FRAC_W-1:0];
      px.light = light[FRAC_W-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      // values read right after the edge are the ones the dut saw at it
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_pixel(px);
      pixels_sent++;
   endtask

   // main stimulus: directed corners, then three random phases
   initial begin
      int unsigned hue;
      int unsigned sat;
      int unsigned light;
      int unsigned pick;
      int          n;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // primaries at full saturation, half lightness
      send_hsl(0, UNIT, HALF_UNIT);
      send_hsl(HUE_THIRD, UNIT, HALF_UNIT);
      send_hsl(2 * HUE_THIRD, UNIT, HALF_UNIT);
      // both sides of every ramp corner
      send_hsl(HUE_RISE - 1, UNIT, HALF_UNIT);
      send_hsl(HUE_RISE, UNIT, HALF_UNIT);
      send_hsl(HUE_HOLD - 1, UNIT, HALF_UNIT);
      send_hsl(HUE_HOLD, UNIT, HALF_UNIT);
      send_hsl(HUE_FALL - 1, UNIT, HALF_UNIT);
      send_hsl(300, UNIT, HALF_UNIT);
      send_hsl(HUE_TURN - 1, UNIT, HALF_UNIT);
      // hue past a full turn wraps around
      send_hsl(HUE_TURN, UNIT, HALF_UNIT);
      send_hsl((1 << HUE_W) - 1, UNIT, HALF_UNIT);
      // gray pixels: no saturation
      send_hsl(200, 0, 0);
      send_hsl(200, 0, UNIT);
      send_hsl(45, 0, 1234);
      // saturation and lightness above one clamp to one
      send_hsl(30, (1 << FRAC_W) - 1, HALF_UNIT);
      send_hsl(30, HALF_UNIT, (1 << FRAC_W) - 1);
      send_hsl((1 << HUE_W) - 1, (1 << FRAC_W) - 1, (1 << FRAC_W) - 1);
      // lightness just below and at one half picks the other hi formula
      send_hsl(90, UNIT, HALF_UNIT - 1);
      send_hsl(90, 3000, HALF_UNIT);
      send_hsl(10, 1, 1);
      send_hsl(150, UNIT - 1, UNIT - 1);
      send_hsl(270, 3000, 0);
      send_hsl(330, 2000, UNIT);

      for (n = 0; n < RANDOM_PIXELS; n++) begin
         if (n == PHASE_PIXELS) begin
            send_idle_pct = 75;
            recv_idle_pct = 31;
         end else if (n == 2 * PHASE_PIXELS) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            // raw field bits, including out-of-range hue and fractions
            hue   = $urandom_range((1 << HUE_W) - 1);
            sat   = $urandom_range((1 << FRAC_W) - 1);
            light = $urandom_range((1 << FRAC_W) - 1);
         end else if (pick < 30) begin
            // near a ramp corner, with an occasional gray or extreme level
            hue   = ($urandom_range(5) * HUE_RISE + $urandom_range(2) + HUE_TURN - 1)
                    % HUE_TURN;
            sat   = ($urandom_range(3) == 0) ? 0 : $urandom_range(UNIT);
            light = ($urandom_range(3) == 0) ? ($urandom_range(1) * UNIT)
                                            : $urandom_range(UNIT);
         end else begin
            hue   = $urandom_range(HUE_TURN - 1);
            sat   = $urandom_range(UNIT);
            light = $urandom_range(UNIT);
         end
         send_hsl(hue, sat, light);
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("hsl_to_rgb_converter_tb: PASS");
      end else begin
         $display("hsl_to_rgb_converter_tb: FAIL");
      end
      $finish;
   end

   // result side: check each rsp beat, then pick tready for the next edge
   initial begin
      int hold_left;
      bit hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_pixel(rgb_pixel_type'(rsp_tdata));
         end
         // one long hold-off while the sender keeps going: the pipe fills and req stalls
         if (!hold_done && pixels_sent >= BACKPRESSURE_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // hang detection: too many cycles in a row without a beat on either side
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("hsl_to_rgb_converter_tb: FAIL");
      $finish;
   end

endmodule
